### sv/rvpm_pkg.sv
// Package for the rotated view pan and map block.
// Holds widths, opcodes, reset values and register indexes; no dependencies.
package rvpm_pkg;
    localparam int SCREEN_W_DEF = 1280;
    localparam int SCREEN_H_DEF = 720;

    localparam logic [1:0] OP_RECENTRE = 2'd0;
    localparam logic [1:0] OP_PAN      = 2'd1;
    localparam logic [1:0] OP_RECT     = 2'd2;
    localparam logic [1:0] OP_TAP      = 2'd3;

    localparam logic [1:0] REG_TURNS = 2'd0;
    localparam logic [1:0] REG_ZOOM  = 2'd1;
    localparam logic [1:0] REG_PW    = 2'd2;
    localparam logic [1:0] REG_PH    = 2'd3;

    localparam logic [15:0] ZOOM_RST = 16'd4096;
    localparam logic [11:0] PW_RST   = 12'd612;
    localparam logic [11:0] PH_RST   = 12'd792;

    // Wide signed working width for exact Q.16 arithmetic
    localparam int AW = 48;

    localparam logic signed [AW-1:0] F20_MIN = -48'sd524288;
    localparam logic signed [AW-1:0] F20_MAX = 48'sd524287;

    typedef logic signed [AW-1:0] acc_t;

    typedef struct packed {
        logic [1:0]  turns;
        logic [15:0] zoom;
        logic [11:0] pw;
        logic [11:0] ph;
    } cfg_t;

    function automatic acc_t sat20(input acc_t v);
        if (v < F20_MIN) return F20_MIN;
        if (v > F20_MAX) return F20_MAX;
        return v;
    endfunction
endpackage

### sv/rvpm_div.sv
// Serial restoring divider: signed numerator by unsigned 16-bit divisor,
// quotient truncated toward zero. Uses rvpm_pkg.
module rvpm_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  rvpm_pkg::acc_t    num,
    input  logic [15:0]       den,
    output logic              done,
    output rvpm_pkg::acc_t    quo
);
    import rvpm_pkg::*;

    localparam int CW = $clog2(AW + 1);

    logic [AW-1:0] q_reg, q_next;
    logic [16:0]   r_reg, r_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          neg_reg, neg_next;
    logic          done_reg, done_next;
    logic [16:0]   trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        neg_next = neg_reg;
        done_next = 1'b0;
        trial = '0;
        if (start) begin
            neg_next = num[AW-1];
            q_next = num[AW-1] ? AW'(-num) : AW'(num);
            r_next = '0;
            cnt_next = CW'(AW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // Shift one numerator bit in, try the subtract
            trial = {r_reg[15:0], q_reg[AW-1]};
            if (trial >= {1'b0, den}) begin
                r_next = trial - {1'b0, den};
                q_next = {q_reg[AW-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[AW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo = neg_reg ? -acc_t'(q_reg) : acc_t'(q_reg);

    assert property (@(posedge aclk) disable iff (!aresetn) done |-> !busy_reg)
        else $error("divider done while busy");
    assert property (@(posedge aclk) disable iff (!aresetn) start |=> busy_reg)
        else $error("divider did not start");
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0)
        else $error("divider count ran out while busy");
endmodule

### sv/rotated_view_pan_and_map_top.sv
// Top level of the rotated view pan and map block.
// Uses rvpm_pkg and rvpm_div (serial divider for the tap mapping).
//
// Usage:
//   s_axis_* carries one request word (opcode, page number, two points);
//   m_axis_* returns exactly one result word per request. The APB port
//   writes quarter_turns, zoom_factor, page_width and page_height at byte
//   addresses 0, 4, 8, 12 and reads them back.
//   The block handles one word at a time on a small sequencer around one
//   shared 21x17 multiplier that runs six steps for every request. Recentre,
//   pan and link rectangle offer their result once those steps are done; a
//   tap adds two serial divisions by the zoom before it offers its result.
//   A new word is taken only once the last result has been taken and the
//   sequencer is back in the idle state.
//   s_axis_tready is high only in the idle state. The result sits in an
//   output register until m_axis_tready takes it; the block stays busy
//   while the receiver stalls.
//   Reset loads the register defaults (0, 1.0, 612, 792) and centres the
//   page on mid-screen.
module rotated_view_pan_and_map_top #(
    parameter int SCREEN_W = rvpm_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = rvpm_pkg::SCREEN_H_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[1:0], page_number[9:2], coord_x[29:10], coord_y[49:30],
    // corner_x[69:50], corner_y[89:70], zero pad
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_x[19:0], result_y[39:20], result_w[58:40], result_h[77:59],
    // on_page[78], zero pad
    output logic [79:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rvpm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_M1   = 3'd1;
    localparam logic [2:0] ST_M2   = 3'd2;
    localparam logic [2:0] ST_M3   = 3'd3;
    localparam logic [2:0] ST_M4   = 3'd4;
    localparam logic [2:0] ST_CALC = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    localparam acc_t CX_RST = acc_t'(SCREEN_W / 2 * 16);
    localparam acc_t CY_RST = acc_t'(SCREEN_H / 2 * 16);
    localparam acc_t SW12 = acc_t'(SCREEN_W) * 4096;
    localparam acc_t SH12 = acc_t'(SCREEN_H) * 4096;
    localparam acc_t SW8 = acc_t'(SCREEN_W * 8);
    localparam acc_t SH8 = acc_t'(SCREEN_H * 8);
    localparam acc_t SW16 = acc_t'(SCREEN_W * 16);
    localparam acc_t SH16 = acc_t'(SCREEN_H * 16);

    cfg_t cfg_reg;
    logic [2:0] st_reg, st_next;
    logic [19:0] cx_reg, cy_reg;
    logic [1:0] op_reg;
    logic [7:0] pg_reg;
    acc_t x0_reg, y0_reg, x1_reg, y1_reg;
    acc_t w12_reg, h12_reg, p0_reg, p1_reg, p2_reg, p3_reg;
    acc_t nx_reg, ny_reg, rx_reg;
    logic div_phase_reg;
    logic [79:0] out_reg, out_next;

    // shared multiplier
    logic signed [20:0] ma;
    acc_t mprod;
    assign mprod = acc_t'(ma) * acc_t'({1'b0, cfg_reg.zoom});

    logic quarter;
    assign quarter = cfg_reg.turns[0];

    logic wr;
    assign wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[3:2])
            REG_TURNS: prdata = {30'd0, cfg_reg.turns};
            REG_ZOOM:  prdata = {16'd0, cfg_reg.zoom};
            REG_PW:    prdata = {20'd0, cfg_reg.pw};
            default:   prdata = {20'd0, cfg_reg.ph};
        endcase
    end

    // divider
    logic div_start, div_done;
    acc_t div_num, div_quo;
    rvpm_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(cfg_reg.zoom), .done(div_done), .quo(div_quo)
    );

    // turn helper
    function automatic void turn(input logic [1:0] t, input acc_t dx, input acc_t dy,
                                 output acc_t ox, output acc_t oy);
        case (t)
            2'd1:    begin ox = -dy; oy = dx; end
            2'd2:    begin ox = -dx; oy = -dy; end
            2'd3:    begin ox = dy; oy = -dx; end
            default: begin ox = dx; oy = dy; end
        endcase
    endfunction

    function automatic acc_t pan_axis(input acc_t c, input acc_t d, input acc_t ext,
                                      input acc_t sc12, input acc_t sc8, input acc_t sc16);
        acc_t half4, lo, v;
        half4 = ext >>> 9;
        lo = sc16 - half4;
        v = c + d;
        if (ext <= sc12) return sc8;
        if (v < lo) v = lo;
        if (v > half4) v = half4;
        return sat20(v);
    endfunction

    acc_t mx, my, tx, ty, ux, uy, sw, sh, rx, ry, rw, rh;
    logic rect_ok, tap_ok;
    assign rect_ok = (pg_reg == 8'd0) && (op_reg == OP_RECT);
    assign tap_ok = (pg_reg == 8'd0) && (op_reg == OP_TAP) && (cfg_reg.zoom != 16'd0);

    always_comb begin
        st_next = st_reg;
        ma = '0;
        div_start = 1'b0;
        // first division takes the x numerator, the second the y numerator
        div_num = (st_reg == ST_CALC) ? nx_reg : ny_reg;
        turn(2'(3'd4 - {1'b0, cfg_reg.turns}), x0_reg, y0_reg, mx, my);
        turn(cfg_reg.turns, p0_reg, p1_reg, tx, ty);
        turn(2'(3'd4 - {1'b0, cfg_reg.turns}), x0_reg - acc_t'($signed(cx_reg)),
             y0_reg - acc_t'($signed(cy_reg)), ux, uy);
        sw = quarter ? p3_reg : p2_reg;
        sh = quarter ? p2_reg : p3_reg;
        rx = (acc_t'($signed(cx_reg)) * 8192 + tx - sw) / 131072;
        ry = (acc_t'($signed(cy_reg)) * 8192 + ty - sh) / 131072;
        rw = sw / 65536;
        rh = sh / 65536;
        case (st_reg)
            ST_M1: begin ma = 21'(cfg_reg.pw); st_next = ST_M2; end
            ST_M2: begin ma = 21'(cfg_reg.ph); st_next = ST_M3; end
            ST_M3: begin ma = 21'(x0_reg + x1_reg); st_next = ST_M4; end
            ST_M4: begin ma = 21'(y0_reg + y1_reg); st_next = ST_CALC; end
            ST_CALC: begin
                ma = 21'(x1_reg - x0_reg);
                st_next = ST_DIV;
            end
            ST_DIV: begin
                ma = 21'(y1_reg - y0_reg);
                if (op_reg == OP_TAP && tap_ok) begin
                    if (div_done) st_next = div_phase_reg ? ST_OUT : ST_DIV;
                end else begin
                    // stay in the divide state until the last product has landed in p3
                    st_next = div_phase_reg ? ST_OUT : ST_DIV;
                end
            end
            ST_OUT: if (m_axis_tready) st_next = ST_IDLE;
            default: if (s_axis_tvalid) st_next = ST_M1;
        endcase
        if (st_reg == ST_CALC && tap_ok) div_start = 1'b1;
        if (st_reg == ST_DIV && tap_ok && div_done && !div_phase_reg) div_start = 1'b1;
    end

    always_comb begin
        out_next = '0;
        if (op_reg == OP_RECT && rect_ok) begin
            out_next[19:0] = 20'(sat20(rx));
            out_next[39:20] = 20'(sat20(ry));
            out_next[58:40] = (rw < 0) ? 19'd0 : (rw > F20_MAX) ? 19'h7FFFF : 19'(rw);
            out_next[77:59] = (rh < 0) ? 19'd0 : (rh > F20_MAX) ? 19'h7FFFF : 19'(rh);
        end else if (tap_ok) begin
            out_next[19:0] = 20'(rx_reg);
            out_next[39:20] = 20'(sat20(div_quo));
            out_next[78] = (nx_reg >= 0) && (ny_reg >= 0) &&
                (nx_reg <= (w12_reg <<< 4)) && (ny_reg <= (h12_reg <<< 4));
        end
    end

    assign s_axis_tready = (st_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            cfg_reg <= '{turns: 2'd0, zoom: ZOOM_RST, pw: PW_RST, ph: PH_RST};
            cx_reg <= 20'(CX_RST);
            cy_reg <= 20'(CY_RST);
            div_phase_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (wr) begin
                case (paddr[3:2])
                    REG_TURNS: cfg_reg.turns <= pwdata[1:0];
                    REG_ZOOM:  cfg_reg.zoom <= pwdata[15:0];
                    REG_PW:    cfg_reg.pw <= pwdata[11:0];
                    default:   cfg_reg.ph <= pwdata[11:0];
                endcase
            end
            if (st_reg == ST_M3) begin
                if (op_reg == OP_RECENTRE) begin
                    cx_reg <= 20'(CX_RST);
                    cy_reg <= 20'(CY_RST);
                end else if (op_reg == OP_PAN) begin
                    cx_reg <= 20'(pan_axis(acc_t'($signed(cx_reg)), mx,
                        quarter ? h12_reg : w12_reg, SW12, SW8, SW16));
                    cy_reg <= 20'(pan_axis(acc_t'($signed(cy_reg)), my,
                        quarter ? w12_reg : h12_reg, SH12, SH8, SH16));
                end
            end
            if (st_reg == ST_CALC) div_phase_reg <= 1'b0;
            else if (st_reg == ST_DIV && (div_done || !tap_ok)) div_phase_reg <= 1'b1;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            op_reg <= s_axis_tdata[1:0];
            pg_reg <= s_axis_tdata[9:2];
            x0_reg <= acc_t'($signed(s_axis_tdata[29:10]));
            y0_reg <= acc_t'($signed(s_axis_tdata[49:30]));
            x1_reg <= acc_t'($signed(s_axis_tdata[69:50]));
            y1_reg <= acc_t'($signed(s_axis_tdata[89:70]));
        end
        if (st_reg == ST_M1) w12_reg <= mprod;
        if (st_reg == ST_M2) h12_reg <= mprod;
        if (st_reg == ST_M3) p0_reg <= mprod - (w12_reg <<< 4);
        if (st_reg == ST_M4) begin
            p1_reg <= mprod - (h12_reg <<< 4);
            nx_reg <= (ux <<< 12) + (w12_reg <<< 3);
            ny_reg <= (uy <<< 12) + (h12_reg <<< 3);
        end
        if (st_reg == ST_CALC) p2_reg <= mprod;
        if (st_reg == ST_DIV) begin
            if (op_reg != OP_TAP) p3_reg <= mprod;
            if (div_done && !div_phase_reg) rx_reg <= sat20(div_quo);
        end
        // Result word is formed on entry to the output state
        if (st_reg == ST_DIV && st_next == ST_OUT) out_reg <= out_next;
    end

    // rect path: p3 is latched in the first divide-state cycle and used in the second
    assign m_axis_tvalid = (st_reg == ST_OUT);
    assign m_axis_tdata = out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input taken while a result is pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> st_reg == ST_M1)
        else $error("sequencer did not start");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule
